[hw/rtl/vsync_frame_pacing_queue_macros.svh]
// Assertion macros for the frame pacing queue RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef VSYNC_FRAME_PACING_QUEUE_MACROS_SVH
`define VSYNC_FRAME_PACING_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VFPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VFPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/vfpq_pkg.sv]
// Package for the frame pacing queue: sizes, codes, shared structs and helpers.
// Depends on nothing; vfpq_in_stage, vfpq_ring and the top level use it by scoped names.
package vfpq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W = 64;
  localparam int FRAME_W = 64;
  localparam int GPU_W = 8;
  localparam int IVL_W = 30;
  localparam int LEVEL_W = 4;
  localparam int STATUS_W = 2;

  localparam longint unsigned NS_PER_SECOND = 64'd1000000000;
  localparam longint unsigned DEFAULT_REFRESH_HZ = 64'd60;
  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(NS_PER_SECOND / DEFAULT_REFRESH_HZ);

  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE = 2'd3;

  typedef struct packed {
    logic func;
    logic [TIME_W-1:0] now_time;
    logic [FRAME_W-1:0] frame_num;
    logic [GPU_W-1:0] gpu_num;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0] target;
    logic [GPU_W-1:0] gpu;
  } ring_ctl_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0] target;
    logic [GPU_W-1:0] gpu;
  } ring_sts_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] sat_inc(input logic [63:0] a);
    return (a == '1) ? a : a + 64'd1;
  endfunction

endpackage

[hw/rtl/vfpq_req_if.sv]
// Request channel of the frame pacing queue: valid, ready and one input item.
// Widths are those of the item fields; no package needed.
interface vfpq_req_if;
  logic valid;
  logic ready;
  logic func;
  logic [63:0] now_time;
  logic [63:0] frame_num;
  logic [7:0] gpu_num;

  modport source (output valid, func, now_time, frame_num, gpu_num, input ready);
  modport sink (input valid, func, now_time, frame_num, gpu_num, output ready);
endinterface

[hw/rtl/vfpq_rsp_if.sv]
// Result channel of the frame pacing queue: valid, ready and one result item.
// Widths are those of the result fields; no package needed.
interface vfpq_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [63:0] out_frame;
  logic [7:0] out_gpu;
  logic [63:0] target_time;
  logic [63:0] jitter;
  logic [3:0] queue_level;
  logic [63:0] paced_total;
  logic [63:0] dropped_total;
  logic [63:0] jitter_sum;

  modport source (output valid, status, out_frame, out_gpu, target_time, jitter,
                  queue_level, paced_total, dropped_total, jitter_sum, input ready);
  modport sink (input valid, status, out_frame, out_gpu, target_time, jitter,
                queue_level, paced_total, dropped_total, jitter_sum, output ready);
endinterface

[hw/rtl/vfpq_in_stage.sv]
// Input register of the frame pacing queue, holding one request item.
// Depends on vfpq_pkg and vfpq_req_if.
module vfpq_in_stage (
  input  logic                clk,
  input  logic                rst,
  vfpq_req_if.sink            req,
  input  logic                take,
  output logic                valid,
  output vfpq_pkg::item_t     item
);

  always_comb begin
    req.ready = !valid || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.func <= req.func;
      item.now_time <= req.now_time;
      item.frame_num <= req.frame_num;
      item.gpu_num <= req.gpu_num;
    end
  end

endmodule

[hw/rtl/vfpq_ring.sv]
// Ring of waiting frames with read and write pointers and a fill count.
// Depends on vfpq_pkg and the assertion macros header.
`include "vsync_frame_pacing_queue_macros.svh"

module vfpq_ring (
  input  logic                  clk,
  input  logic                  rst,
  input  vfpq_pkg::ring_ctl_t   ctl,
  output vfpq_pkg::ring_sts_t   sts
);

  logic [vfpq_pkg::FRAME_W-1:0] slot_frame [vfpq_pkg::QUEUE_DEPTH];
  logic [vfpq_pkg::TIME_W-1:0]  slot_target [vfpq_pkg::QUEUE_DEPTH];
  logic [vfpq_pkg::GPU_W-1:0]   slot_gpu [vfpq_pkg::QUEUE_DEPTH];
  logic [vfpq_pkg::PTR_W-1:0]   write_pos;
  logic [vfpq_pkg::PTR_W-1:0]   read_pos;
  logic [vfpq_pkg::FILL_W-1:0]  fill;
  logic [vfpq_pkg::PTR_W-1:0]   write_pos_next;
  logic [vfpq_pkg::PTR_W-1:0]   read_pos_next;

  localparam logic [vfpq_pkg::PTR_W-1:0] LAST_POS = vfpq_pkg::PTR_W'(vfpq_pkg::QUEUE_DEPTH - 1);

  always_comb begin
    write_pos_next = (write_pos == LAST_POS) ? '0 : write_pos + 1'b1;
    read_pos_next = (read_pos == LAST_POS) ? '0 : read_pos + 1'b1;
    sts.fill = fill;
    sts.frame = slot_frame[read_pos];
    sts.target = slot_target[read_pos];
    sts.gpu = slot_gpu[read_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      read_pos <= '0;
      fill <= '0;
    end else begin
      if (ctl.push) begin
        write_pos <= write_pos_next;
        fill <= fill + 1'b1;
      end else if (ctl.pop) begin
        read_pos <= read_pos_next;
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slot_frame[write_pos] <= ctl.frame;
      slot_target[write_pos] <= ctl.target;
      slot_gpu[write_pos] <= ctl.gpu;
    end
  end

  `VFPQ_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= vfpq_pkg::FILL_W'(vfpq_pkg::QUEUE_DEPTH), "ring fill count exceeds depth")
  `VFPQ_ASSERT_IMP(a_push_room, clk, rst, ctl.push, (fill < vfpq_pkg::FILL_W'(vfpq_pkg::QUEUE_DEPTH)) && !ctl.pop, "push into a full ring or together with a pop")
  `VFPQ_ASSERT_IMP(a_pop_data, clk, rst, ctl.pop, fill != '0, "pop from an empty ring")
  `VFPQ_ASSERT_IMP(a_empty_ptrs, clk, rst, fill == '0, write_pos == read_pos, "pointers differ while the ring is empty")

endmodule

[hw/rtl/vsync_frame_pacing_queue.sv]
// Frame pacing queue: stamps submitted frames with vsync targets and releases them on ticks.
// Top level; depends on vfpq_pkg, vfpq_req_if, vfpq_rsp_if, vfpq_in_stage and vfpq_ring.
//
// Requests arrive on req (valid/ready); each transfer is a submit or a tick and gives
// exactly one result transfer on rsp, in order. A submit is stamped with a target time
// and queued, or dropped and counted when all eight slots are full. A tick releases the
// oldest frame once its target has been reached and reports its jitter.
// An accepted request waits in the input register until it is taken; its result is then
// registered in the output register and offered on rsp until the receiver accepts it.
// Throughput is one item per cycle while rsp.ready stays high: each item needs only one pass of adds and compares
// against the ring head and the stored statistics.
// cfg_we writes the frame interval from cfg_data; a zero value is ignored. Write it only
// while no request is in flight.
// A synchronous reset empties the queue, clears the statistics and the last presentation
// time, and restores the 60 Hz interval. When the receiver holds rsp.ready low, the
// result stays put and the input register fills, after which req.ready falls.
module vsync_frame_pacing_queue (
  input  logic                          clk,
  input  logic                          rst,
  vfpq_req_if.sink                      req,
  vfpq_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic [vfpq_pkg::IVL_W-1:0]    cfg_data
);

  logic                            s1_valid;
  vfpq_pkg::item_t                 s1_item;
  logic                            take;
  vfpq_pkg::ring_ctl_t             ring_ctl;
  vfpq_pkg::ring_sts_t             ring_sts;

  logic [vfpq_pkg::IVL_W-1:0]      frame_interval;
  logic [vfpq_pkg::TIME_W-1:0]     last_present;
  logic [63:0]                     paced_count;
  logic [63:0]                     dropped_count;
  logic [63:0]                     jitter_total;

  logic                            out_valid;
  logic [vfpq_pkg::STATUS_W-1:0]   out_status;
  logic [vfpq_pkg::FRAME_W-1:0]    out_frame;
  logic [vfpq_pkg::GPU_W-1:0]      out_gpu;
  logic [vfpq_pkg::TIME_W-1:0]     out_target;
  logic [vfpq_pkg::TIME_W-1:0]     out_jitter;
  logic [vfpq_pkg::LEVEL_W-1:0]    out_level;

  logic [vfpq_pkg::STATUS_W-1:0]   status_next;
  logic [vfpq_pkg::FRAME_W-1:0]    frame_next;
  logic [vfpq_pkg::GPU_W-1:0]      gpu_next;
  logic [vfpq_pkg::TIME_W-1:0]     target_next;
  logic [vfpq_pkg::TIME_W-1:0]     jitter_next;
  logic [vfpq_pkg::FILL_W-1:0]     fill_next;
  logic [vfpq_pkg::TIME_W-1:0]     base;
  logic [vfpq_pkg::TIME_W-1:0]     tgt_last;
  logic [vfpq_pkg::TIME_W-1:0]     tgt_now;
  logic [vfpq_pkg::TIME_W-1:0]     tgt;
  logic [vfpq_pkg::TIME_W-1:0]     late;
  logic                            full;
  logic                            due;

  vfpq_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .take  (take),
    .valid (s1_valid),
    .item  (s1_item)
  );

  vfpq_ring u_ring (
    .clk (clk),
    .rst (rst),
    .ctl (ring_ctl),
    .sts (ring_sts)
  );

  always_comb begin
    take = s1_valid && (!out_valid || rsp.ready);

    base = (last_present != '0) ? last_present : s1_item.now_time;
    tgt_last = vfpq_pkg::sat_add(base, 64'(frame_interval));
    tgt_now = vfpq_pkg::sat_add(s1_item.now_time, 64'(frame_interval));
    tgt = (tgt_last < s1_item.now_time) ? tgt_now : tgt_last;
    full = ring_sts.fill == vfpq_pkg::FILL_W'(vfpq_pkg::QUEUE_DEPTH);
    due = (ring_sts.fill != '0) && (s1_item.now_time >= ring_sts.target);
    late = s1_item.now_time - ring_sts.target;

    ring_ctl.push = 1'b0;
    ring_ctl.pop = 1'b0;
    ring_ctl.frame = s1_item.frame_num;
    ring_ctl.target = tgt;
    ring_ctl.gpu = s1_item.gpu_num;

    status_next = vfpq_pkg::ST_IDLE;
    frame_next = '0;
    gpu_next = '0;
    target_next = '0;
    jitter_next = '0;
    fill_next = ring_sts.fill;

    if (s1_item.func == vfpq_pkg::FUNC_SUBMIT) begin
      if (full) begin
        status_next = vfpq_pkg::ST_DROPPED;
      end else begin
        ring_ctl.push = take;
        status_next = vfpq_pkg::ST_ACCEPTED;
        frame_next = s1_item.frame_num;
        gpu_next = s1_item.gpu_num;
        target_next = tgt;
        fill_next = ring_sts.fill + 1'b1;
      end
    end else if (due) begin
      ring_ctl.pop = take;
      status_next = vfpq_pkg::ST_RELEASED;
      frame_next = ring_sts.frame;
      gpu_next = ring_sts.gpu;
      target_next = ring_sts.target;
      jitter_next = late;
      fill_next = ring_sts.fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_interval <= vfpq_pkg::IVL_RESET;
    end else if (cfg_we && (cfg_data != '0)) begin
      frame_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_present <= '0;
      paced_count <= '0;
      dropped_count <= '0;
      jitter_total <= '0;
    end else if (take) begin
      if (ring_ctl.pop) begin
        last_present <= s1_item.now_time;
        paced_count <= vfpq_pkg::sat_inc(paced_count);
        jitter_total <= vfpq_pkg::sat_add(jitter_total, late);
      end
      if (status_next == vfpq_pkg::ST_DROPPED) begin
        dropped_count <= vfpq_pkg::sat_inc(dropped_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= status_next;
      out_frame <= frame_next;
      out_gpu <= gpu_next;
      out_target <= target_next;
      out_jitter <= jitter_next;
      out_level <= vfpq_pkg::LEVEL_W'(fill_next);
    end
  end

  always_comb begin
    rsp.valid = out_valid;
    rsp.status = out_status;
    rsp.out_frame = out_frame;
    rsp.out_gpu = out_gpu;
    rsp.target_time = out_target;
    rsp.jitter = out_jitter;
    rsp.queue_level = out_level;
    rsp.paced_total = paced_count;
    rsp.dropped_total = dropped_count;
    rsp.jitter_sum = jitter_total;
  end

endmodule

[test/tb.sv]
// Self-checking testbench for vsync_frame_pacing_queue: submits and ticks with
// random idling on both channels, each result checked against a local pacing model.
// Depends on vfpq_pkg, vfpq_req_if, vfpq_rsp_if and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [vfpq_pkg::STATUS_W-1:0] status;
    logic [vfpq_pkg::FRAME_W-1:0]  frame;
    logic [vfpq_pkg::GPU_W-1:0]    gpu;
    logic [vfpq_pkg::TIME_W-1:0]   target;
    logic [vfpq_pkg::TIME_W-1:0]   jitter;
    logic [vfpq_pkg::LEVEL_W-1:0]  level;
    logic [63:0]                   paced;
    logic [63:0]                   dropped;
    logic [63:0]                   jitter_sum;
  } pace_rsp_t;

  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 120;
  localparam logic [63:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [vfpq_pkg::IVL_W-1:0] cfg_data = '0;

  logic drv_valid = 1'b0;
  vfpq_pkg::item_t drv_item = '0;
  logic rsp_ready = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int accepted_n = 0;
  int mismatches = 0;
  bit idle_on = 1'b1;

  vfpq_pkg::item_t pending_items[$];
  pace_rsp_t pacing_results[$];
  pace_rsp_t want;

  logic [vfpq_pkg::FRAME_W-1:0] ring_frame [vfpq_pkg::QUEUE_DEPTH];
  logic [vfpq_pkg::TIME_W-1:0]  ring_target [vfpq_pkg::QUEUE_DEPTH];
  logic [vfpq_pkg::GPU_W-1:0]   ring_gpu [vfpq_pkg::QUEUE_DEPTH];
  int wr_slot = 0;
  int rd_slot = 0;
  int held = 0;
  logic [63:0] last_shown = '0;
  logic [63:0] paced_n = '0;
  logic [63:0] dropped_n = '0;
  logic [63:0] jitter_acc = '0;
  logic [vfpq_pkg::IVL_W-1:0] interval_ns = vfpq_pkg::IVL_RESET;
  logic [63:0] wall = '0;

  vfpq_req_if req_if ();
  vfpq_rsp_if rsp_if ();

  assign req_if.valid = drv_valid;
  assign req_if.func = drv_item.func;
  assign req_if.now_time = drv_item.now_time;
  assign req_if.frame_num = drv_item.frame_num;
  assign req_if.gpu_num = drv_item.gpu_num;
  assign rsp_if.ready = rsp_ready;

  vsync_frame_pacing_queue dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] clamp_sum(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? TIME_MAX : s[63:0];
  endfunction

  function automatic pace_rsp_t pace_item(input vfpq_pkg::item_t it);
    pace_rsp_t r;
    logic [63:0] base;
    logic [63:0] tgt;
    r = '0;
    if (it.func == vfpq_pkg::FUNC_SUBMIT) begin
      if (held >= vfpq_pkg::QUEUE_DEPTH) begin
        dropped_n = clamp_sum(dropped_n, 64'd1);
        r.status = vfpq_pkg::ST_DROPPED;
      end else begin
        base = (last_shown != 0) ? last_shown : it.now_time;
        tgt = clamp_sum(base, {34'd0, interval_ns});
        if (tgt < it.now_time) tgt = clamp_sum(it.now_time, {34'd0, interval_ns});
        ring_frame[wr_slot] = it.frame_num;
        ring_target[wr_slot] = tgt;
        ring_gpu[wr_slot] = it.gpu_num;
        wr_slot = (wr_slot + 1) % vfpq_pkg::QUEUE_DEPTH;
        held++;
        r.status = vfpq_pkg::ST_ACCEPTED;
        r.frame = it.frame_num;
        r.gpu = it.gpu_num;
        r.target = tgt;
      end
    end else begin
      if (held > 0 && it.now_time >= ring_target[rd_slot]) begin
        r.frame = ring_frame[rd_slot];
        r.gpu = ring_gpu[rd_slot];
        r.target = ring_target[rd_slot];
        r.jitter = it.now_time - r.target;
        rd_slot = (rd_slot + 1) % vfpq_pkg::QUEUE_DEPTH;
        held--;
        paced_n = clamp_sum(paced_n, 64'd1);
        jitter_acc = clamp_sum(jitter_acc, r.jitter);
        last_shown = it.now_time;
        r.status = vfpq_pkg::ST_RELEASED;
      end else begin
        r.status = vfpq_pkg::ST_IDLE;
      end
    end
    r.level = held[vfpq_pkg::LEVEL_W-1:0];
    r.paced = paced_n;
    r.dropped = dropped_n;
    r.jitter_sum = jitter_acc;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic offer(input logic f, input logic [63:0] now, input logic [63:0] fid,
                       input logic [7:0] g);
    pending_items.push_back(vfpq_pkg::item_t'{func: f, now_time: now, frame_num: fid,
                                              gpu_num: g});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || drv_valid || pacing_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_interval(input logic [vfpq_pkg::IVL_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    if (v != 0) interval_ns = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int burst;
    int unsigned span;
    int unsigned adv;
    logic f;
    burst = 0;
    span = {2'b00, interval_ns};
    for (int i = 0; i < n; i++) begin
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(8, 12);
      if ($urandom_range(0, 3) == 0) adv = $urandom_range(0, span * 3);
      else adv = $urandom_range(0, span / 2);
      wall = wall + 64'(adv);
      if (burst > 0) begin
        burst--;
        f = vfpq_pkg::FUNC_SUBMIT;
      end else begin
        f = $urandom_range(0, 1) ? vfpq_pkg::FUNC_TICK : vfpq_pkg::FUNC_SUBMIT;
      end
      offer(f, wall, {$urandom, $urandom}, 8'($urandom));
    end
  endtask

  // Request driver: predicts each result at the transfer of its request.
  always @(posedge clk) begin
    if (!rst) begin
      if (drv_valid && req_if.ready) begin
        pacing_results.push_back(pace_item(drv_item));
        accepted_n <= accepted_n + 1;
      end
      if (!drv_valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          drv_valid <= 1'b0;
        end else if (idle_on && hold_left == 0 && pending_items.size() != 0 &&
                     $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 12);
          drv_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          drv_item <= pending_items.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // A single long hold-off of the result channel, so that the block fills up.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_n >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ready && rsp_if.valid) begin
        if (pacing_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result transfer with nothing expected, expected none, actual %h",
                   $time, rsp_if.status);
        end else begin
          want = pacing_results.pop_front();
          check_field("status", want.status, rsp_if.status);
          check_field("out_frame", want.frame, rsp_if.out_frame);
          check_field("out_gpu", want.gpu, rsp_if.out_gpu);
          check_field("target_time", want.target, rsp_if.target_time);
          check_field("jitter", want.jitter, rsp_if.jitter);
          check_field("queue_level", want.level, rsp_if.queue_level);
          check_field("paced_total", want.paced, rsp_if.paced_total);
          check_field("dropped_total", want.dropped, rsp_if.dropped_total);
          check_field("jitter_sum", want.jitter_sum, rsp_if.jitter_sum);
        end
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 12);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin
    #1000000;
    $display("** vsync_frame_pacing_queue: FAILED **");
    $finish;
  end

  initial begin
    logic [63:0] d;
    logic [63:0] t;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset interval; empty queue, first submit with no presentation yet, early and due ticks.
    d = {34'd0, vfpq_pkg::IVL_RESET};
    offer(vfpq_pkg::FUNC_TICK, 64'd0, 64'd0, 8'd0);
    offer(vfpq_pkg::FUNC_SUBMIT, 64'd0, 64'd0, 8'd0);
    offer(vfpq_pkg::FUNC_SUBMIT, 64'd5, TIME_MAX, 8'hFF);
    offer(vfpq_pkg::FUNC_TICK, d - 1, TIME_MAX, 8'hFF);
    offer(vfpq_pkg::FUNC_TICK, d, 64'd0, 8'd0);
    offer(vfpq_pkg::FUNC_TICK, d + 105, {$urandom, $urandom}, 8'($urandom));
    offer(vfpq_pkg::FUNC_TICK, d + 200, 64'd0, 8'd0);
    // Targets already past, then a full queue with drops.
    for (int i = 0; i < 10; i++) begin
      offer(vfpq_pkg::FUNC_SUBMIT, d * 10, {$urandom, $urandom}, 8'($urandom));
    end
    offer(vfpq_pkg::FUNC_TICK, d * 11, 64'd0, 8'd0);
    offer(vfpq_pkg::FUNC_SUBMIT, d * 11, {$urandom, $urandom}, 8'($urandom));
    offer(vfpq_pkg::FUNC_SUBMIT, d * 11, {$urandom, $urandom}, 8'($urandom));
    offer(vfpq_pkg::FUNC_TICK, d * 12, 64'd0, 8'd0);
    offer(vfpq_pkg::FUNC_TICK, d * 13, 64'd0, 8'd0);
    wall = d * 13;
    wait_drained();

    // A zero write leaves the interval unchanged.
    set_interval('0);
    random_phase(150);
    wait_drained();

    set_interval(30'd1);
    random_phase(150);
    wait_drained();

    set_interval('1);
    random_phase(150);
    wait_drained();

    set_interval(vfpq_pkg::IVL_W'($urandom_range(100, 100000)));
    random_phase(200);
    wait_drained();

    idle_on = 1'b0;
    set_interval(vfpq_pkg::IVL_W'($urandom_range(1, 32'h3FFF_FFFF)));
    random_phase(300);
    wait_drained();

    // Drain, then release at the top of the time range: saturating jitter sum and target.
    set_interval(30'd1000);
    t = wall + 64'h2_0000_0000;
    for (int i = 0; i < 9; i++) offer(vfpq_pkg::FUNC_TICK, t, 64'd0, 8'd0);
    for (int i = 0; i < 3; i++) begin
      offer(vfpq_pkg::FUNC_SUBMIT, t, {$urandom, $urandom}, 8'($urandom));
    end
    for (int i = 0; i < 3; i++) offer(vfpq_pkg::FUNC_TICK, TIME_MAX, TIME_MAX, 8'hFF);
    offer(vfpq_pkg::FUNC_SUBMIT, TIME_MAX, TIME_MAX, 8'hFF);
    offer(vfpq_pkg::FUNC_TICK, TIME_MAX, 64'd0, 8'd0);
    offer(vfpq_pkg::FUNC_TICK, TIME_MAX, 64'd0, 8'd0);
    wait_drained();
    repeat (6) @(posedge clk);

    if (mismatches == 0 && pacing_results.size() == 0) begin
      $display("** vsync_frame_pacing_queue: PASSED **");
    end else begin
      $display("** vsync_frame_pacing_queue: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/vfpq_pkg.sv
hw/rtl/vfpq_req_if.sv
hw/rtl/vfpq_rsp_if.sv
hw/rtl/vfpq_in_stage.sv
hw/rtl/vfpq_ring.sv
hw/rtl/vsync_frame_pacing_queue.sv
test/tb.sv
